/* rtl/mrcf_pkg.sv */
// Package for the mask grid fill block: grid sizes, coordinate and command types.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
package mrcf_pkg;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;
  localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;

  typedef logic signed [17:0] coord_t;

  localparam coord_t GW_C = coord_t'(GRID_W);
  localparam coord_t GH_C = coord_t'(GRID_H);

  typedef enum logic [1:0] {
    ACT_RECT = 2'd0,
    ACT_CIRC = 2'd1,
    ACT_READ = 2'd2,
    ACT_NOP  = 2'd3
  } act_t;

  typedef struct packed {
    act_t               action;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] span_w;
    logic signed [15:0] span_h;
    logic [14:0]        radius;
    logic               fill_value;
  } in_word_t;

  typedef struct packed {
    logic read_value;
    logic is_read_reply;
  } out_word_t;

  // classified command held in the queue
  typedef struct packed {
    act_t        kind;
    logic        fill;
    logic        empty;
    logic [YW-1:0] ylo;
    logic [YW-1:0] yhi;
    coord_t      xa;
    coord_t      xb;
    coord_t      cy;
    logic [14:0] rad;
  } cmd_t;

  function automatic coord_t sx16(input logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

endpackage

/* rtl/mask_rect_circle_fill_top.sv */
// Top level of the mask grid fill block: front queue plus back executor.
// Depends on mrcf_pkg, mrcf_front, mrcf_back.
`timescale 1ns / 1ps
// A 256 x 256 one-bit mask, set to all ones by a clearing pass after reset
// (busy stays high meanwhile). Commands are taken when start is high and busy
// low; a two-word queue lets up to two wait while one executes. Each command
// gives one result word, shown for one cycle with out_valid; the receiver cannot
// stall it. Once out of the queue, an empty or unused command answers from idle,
// a read registers its mask row and then picks the bit, a rectangle writes its
// clipped rows in turn, and a circle, row by row, squares the row offset, runs the
// 15-step square root unit for the row half-width, forms the span and writes it.
module mask_rect_circle_fill_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mrcf_pkg::in_word_t in_cmd,
  output logic               out_valid,
  output mrcf_pkg::out_word_t out_res
);
  import mrcf_pkg::*;

  logic q_valid, q_pop, clearing;
  cmd_t q_entry;

  mrcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_cmd   (in_cmd),
    .clearing (clearing),
    .busy     (busy),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  mrcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> busy)
    else $error("busy low right after reset");
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.is_read_reply |-> !out_res.read_value)
    else $error("non-read result carries a value");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("command popped during clear");
`endif

endmodule

/* rtl/mrcf_front.sv */
// Front end: accepts command words, clips their row ranges to the grid, queues them.
// Depends on mrcf_pkg.
`timescale 1ns / 1ps
module mrcf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mrcf_pkg::in_word_t in_cmd,
  input  logic              clearing,
  output logic              busy,
  output logic              q_valid,
  output mrcf_pkg::cmd_t    q_entry,
  input  logic              q_pop
);
  import mrcf_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cls;
  coord_t     x, y, w, h, r, lo_s, hi_s, t_lo, t_hi, hi_m1;

  assign busy    = (cnt_r == 2'd2) || clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_entry = q_mem_r[rp_r];

  always_comb begin
    x = sx16(in_cmd.x_pos);
    y = sx16(in_cmd.y_pos);
    w = sx16(in_cmd.span_w);
    h = sx16(in_cmd.span_h);
    r = coord_t'({3'b000, in_cmd.radius});
    lo_s = '0;
    hi_s = '0;
    hi_m1 = '0;
    t_lo = '0;
    t_hi = '0;
    cls = '0;
    cls.kind = in_cmd.action;
    cls.fill = in_cmd.fill_value;
    cls.rad  = in_cmd.radius;
    cls.cy   = y;
    cls.xa   = x;
    cls.xb   = x + w;
    cls.empty = 1'b1;
    case (in_cmd.action)
      ACT_RECT: begin
        t_hi = y + h;
        lo_s = (y < 0) ? coord_t'(0) : y;
        hi_s = (t_hi > GH_C) ? GH_C : t_hi;
        hi_m1 = hi_s - coord_t'(1);
        cls.empty = (lo_s >= hi_s);
        cls.ylo = lo_s[YW-1:0];
        cls.yhi = hi_m1[YW-1:0];
      end
      ACT_CIRC: begin
        t_lo = y - r;
        t_hi = y + r;
        lo_s = (t_lo < 0) ? coord_t'(0) : t_lo;
        hi_s = (t_hi > GH_C - coord_t'(1)) ? GH_C - coord_t'(1) : t_hi;
        cls.empty = (lo_s > hi_s);
        cls.ylo = lo_s[YW-1:0];
        cls.yhi = hi_s[YW-1:0];
      end
      ACT_READ: begin
        cls.empty = !(x >= 0 && x < GW_C && y >= 0 && y < GH_C);
        cls.ylo = y[YW-1:0];
        cls.yhi = y[YW-1:0];
      end
      default: begin
        cls.empty = 1'b1;
      end
    endcase
  end

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cls;
    end
  end

endmodule

/* rtl/mrcf_back.sv */
// Back end: mask memory (one row per word), clear pass, span writer, row sqrt unit.
// Depends on mrcf_pkg.
`timescale 1ns / 1ps
module mrcf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mrcf_pkg::cmd_t     q_entry,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  output mrcf_pkg::out_word_t out_res
);
  import mrcf_pkg::*;

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_RECT = 10'b0000000100,
    S_CMUL = 10'b0000001000,
    S_SQI  = 10'b0000010000,
    S_SQ   = 10'b0000100000,
    S_CSP  = 10'b0001000000,
    S_CWR  = 10'b0010000000,
    S_RD   = 10'b0100000000,
    S_RD2  = 10'b1000000000
  } st_t;

  st_t         st_r, st_nxt;
  cmd_t        cur_r;
  logic [YW-1:0] row_r;
  coord_t      sa_r, sb_r;
  logic [29:0] r2_r, dy2_r, rem_r, root_r, bit_r;
  logic [30:0] trial;
  coord_t      dy, dspan;
  logic [14:0] ady;
  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_W-1:0] rd_row_r;
  logic [GRID_W-1:0] wmask;
  logic        we, wval;
  logic        done;
  out_word_t   res;
  logic        out_valid_r;
  out_word_t   out_res_r;

  assign clearing  = (st_r == S_CLR);
  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign dy    = coord_t'({{(18-YW){1'b0}}, row_r}) - cur_r.cy;
  assign ady   = dy[17] ? 15'(-dy) : dy[14:0];
  assign trial = {1'b0, root_r} + {1'b0, bit_r};
  assign dspan = coord_t'({3'b000, root_r[14:0]});

  always_comb begin
    we   = (st_r == S_CLR) || (st_r == S_RECT) || (st_r == S_CWR);
    wval = (st_r == S_CLR) ? 1'b1 : cur_r.fill;
    for (int i = 0; i < GRID_W; i++) begin
      wmask[i] = (st_r == S_CLR) ||
                 ((coord_t'(i) >= sa_r) && (coord_t'(i) < sb_r));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < GRID_W; i++) begin
        if (wmask[i]) begin
          mem[row_r][i] <= wval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= mem[row_r];
  end

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    res    = '0;
    case (st_r)
      S_CLR: begin
        if (row_r == YW'(GRID_H - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          if (q_entry.empty) begin
            done = 1'b1;
            res.is_read_reply = (q_entry.kind == ACT_READ);
            res.read_value    = (q_entry.kind == ACT_READ);
          end else begin
            case (q_entry.kind)
              ACT_RECT: st_nxt = S_RECT;
              ACT_CIRC: st_nxt = S_CMUL;
              ACT_READ: st_nxt = S_RD;
              default:  done   = 1'b1;
            endcase
          end
        end
      end
      S_RECT: begin
        if (row_r == cur_r.yhi) begin
          done   = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_CMUL: st_nxt = S_SQI;
      S_SQI:  st_nxt = S_SQ;
      S_SQ: begin
        if (bit_r[0]) begin
          st_nxt = S_CSP;
        end
      end
      S_CSP: st_nxt = S_CWR;
      S_CWR: begin
        if (row_r == cur_r.yhi) begin
          done   = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_CMUL;
        end
      end
      S_RD: st_nxt = S_RD2;
      S_RD2: begin
        done = 1'b1;
        res.is_read_reply = 1'b1;
        res.read_value    = rd_row_r[sa_r[XW-1:0]];
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= done;
      case (st_r)
        S_CLR:  row_r <= row_r + YW'(1);
        S_IDLE: if (q_valid) row_r <= q_entry.ylo;
        S_RECT, S_CWR: row_r <= row_r + YW'(1);
        default: row_r <= row_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= res;
    case (st_r)
      S_IDLE: begin
        cur_r <= q_entry;
        sa_r  <= q_entry.xa;
        sb_r  <= q_entry.xb;
        r2_r  <= 30'(q_entry.rad) * 30'(q_entry.rad);
      end
      S_CMUL: dy2_r <= 30'(ady) * 30'(ady);
      S_SQI: begin
        rem_r  <= r2_r - dy2_r;
        root_r <= '0;
        bit_r  <= 30'd1 << 28;
      end
      S_SQ: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_r  <= rem_r - trial[29:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_CSP: begin
        sa_r <= cur_r.xa - dspan;
        sb_r <= cur_r.xa + dspan + coord_t'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/mask_fill_checker.sv */
// Checker for the mask grid fill block: keeps its own mask, predicts each result word.
// Depends on mrcf_pkg; watches the command and result ports of the block.
`timescale 1ns / 1ps
module mask_fill_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  mrcf_pkg::in_word_t  in_cmd,
  input  logic                out_valid,
  input  mrcf_pkg::out_word_t out_res,
  output int                  fail_count,
  output int                  pending
);
  import mrcf_pkg::*;

  localparam int GW = GRID_W;
  localparam int GH = GRID_H;

  logic      mask_copy [GW*GH];
  out_word_t reply_q[$];
  int        mismatch_count;

  function automatic int isqrt_floor(input longint n);
    longint root;
    root = 0;
    while ((root + 1) * (root + 1) <= n) root++;
    return int'(root);
  endfunction

  function automatic void paint_row(input int yy, input int x0, input int x1,
                                    input logic v);
    if (yy < 0 || yy >= GH) return;
    if (x0 < 0) x0 = 0;
    if (x1 > GW) x1 = GW;
    for (int xx = x0; xx < x1; xx++) mask_copy[yy*GW + xx] = v;
  endfunction

  function automatic out_word_t apply_command(input in_word_t c);
    out_word_t r;
    int x, y, w, h, rr, y0, y1, d;
    r = '0;
    x = int'(c.x_pos);
    y = int'(c.y_pos);
    w = int'(c.span_w);
    h = int'(c.span_h);
    rr = int'(c.radius);
    case (c.action)
      ACT_RECT: begin
        y0 = (y < 0) ? 0 : y;
        y1 = (y + h > GH) ? GH : y + h;
        for (int yy = y0; yy < y1; yy++) paint_row(yy, x, x + w, c.fill_value);
      end
      ACT_CIRC: begin
        y0 = (y - rr < 0) ? 0 : y - rr;
        y1 = (y + rr > GH - 1) ? GH - 1 : y + rr;
        for (int yy = y0; yy <= y1; yy++) begin
          d = isqrt_floor(longint'(rr) * rr - longint'(yy - y) * (yy - y));
          paint_row(yy, x - d, x + d + 1, c.fill_value);
        end
      end
      ACT_READ: begin
        r.is_read_reply = 1'b1;
        if (x >= 0 && x < GW && y >= 0 && y < GH) r.read_value = mask_copy[y*GW + x];
        else r.read_value = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign fail_count = mismatch_count;
  assign pending    = reply_q.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < GW*GH; i++) mask_copy[i] = 1'b1;
      reply_q.delete();
      mismatch_count <= 0;
    end else begin
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result word %b", out_res);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_w = reply_q.pop_front();
          if (exp_w !== out_res) begin
            if (mismatch_count < 10)
              $display("result mismatch: read_value exp %b got %b, is_read_reply exp %b got %b",
                       exp_w.read_value, out_res.read_value,
                       exp_w.is_read_reply, out_res.is_read_reply);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy) reply_q.push_back(apply_command(in_cmd));
    end
  end
endmodule

/* tb/tb.sv */
// Testbench top for mask_rect_circle_fill_top: clock, reset, command stimulus, verdict.
// Depends on mrcf_pkg, mask_fill_checker and the block under test.
`timescale 1ns / 1ps
module tb;
  import mrcf_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic      clk, rst_n, start, busy, out_valid;
  in_word_t  in_cmd;
  out_word_t out_res;
  int        fail_count, pending;
  int        idle_cycles;
  int        gap_pct;
  bit        timed_out;

  mask_rect_circle_fill_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .out_valid(out_valid), .out_res(out_res)
  );

  mask_fill_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
    .out_valid(out_valid), .out_res(out_res), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
  end

  // Drive one command word and hold it until taken; random gaps before it.
  // busy is checked at the falling edge, where it holds the value of the next rise.
  task automatic send_word(input in_word_t c);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_cmd <= c;
    @(negedge clk);
    while (busy && !timed_out) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(20)) - 16'sd10;
      2:       return 16'sd240 + 16'($urandom_range(30));
      default: return 16'($urandom_range(255));
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t c;
    c.action     = act_t'($urandom_range(99) < 55 ? ACT_READ :
                          ($urandom_range(99) < 5 ? ACT_NOP :
                           ($urandom_range(1) ? ACT_RECT : ACT_CIRC)));
    c.x_pos      = pick_coord();
    c.y_pos      = pick_coord();
    c.span_w     = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(40)) - 16'sd4;
    c.span_h     = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(40)) - 16'sd4;
    c.radius     = ($urandom_range(29) == 0) ? 15'($urandom) : 15'($urandom_range(24));
    c.fill_value = 1'($urandom);
    return c;
  endfunction

  function automatic in_word_t mk(input act_t a, input int x, input int y, input int w,
                                  input int h, input int r, input logic v);
    in_word_t c;
    c.action = a; c.x_pos = 16'(x); c.y_pos = 16'(y); c.span_w = 16'(w);
    c.span_h = 16'(h); c.radius = 15'(r); c.fill_value = v;
    return c;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending != 0 && !timed_out) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_cmd = '0; gap_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        send_word(mk(ACT_READ, 0, 0, 0, 0, 0, 0));
        send_word(mk(ACT_READ, 255, 255, 0, 0, 0, 0));
        send_word(mk(ACT_READ, -1, 5, 0, 0, 0, 0));
        send_word(mk(ACT_READ, 256, 5, 0, 0, 0, 0));
        send_word(mk(ACT_READ, -32768, 32767, 0, 0, 0, 0));
        send_word(mk(ACT_RECT, 0, 0, 256, 256, 0, 0));
        send_word(mk(ACT_READ, 128, 128, 0, 0, 0, 0));
        send_word(mk(ACT_RECT, 10, 10, 0, 5, 0, 1));
        send_word(mk(ACT_RECT, 10, 10, 5, -3, 0, 1));
        send_word(mk(ACT_RECT, 300, 300, 5, 5, 0, 1));
        send_word(mk(ACT_RECT, -32768, -32768, 32767, 32767, 0, 1));
        send_word(mk(ACT_READ, 0, 0, 0, 0, 0, 0));
        send_word(mk(ACT_RECT, -5, 250, 20, 20, 0, 0));
        send_word(mk(ACT_READ, 14, 255, 0, 0, 0, 0));
        send_word(mk(ACT_CIRC, 100, 100, 0, 0, 0, 1));
        send_word(mk(ACT_CIRC, 400, 400, 0, 0, 5, 0));
        send_word(mk(ACT_CIRC, 0, 0, 0, 0, 20, 0));
        send_word(mk(ACT_READ, 14, 14, 0, 0, 0, 0));
        send_word(mk(ACT_CIRC, 128, 128, 0, 0, 32767, 0));
        send_word(mk(ACT_CIRC, 250, 3, 0, 0, 10, 1));
        send_word(mk(ACT_NOP, 3, 3, 3, 3, 3, 1));
        send_word(mk(ACT_READ, 3, 3, 0, 0, 0, 0));
        drain();
        for (int ph = 0; ph < 3; ph++) begin
          gap_pct = (ph == 0) ? 12 : (ph == 1) ? 72 : 0;
          for (int i = 0; i < 640 && !timed_out; i++) send_word(random_word());
          drain();
        end
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("mask_rect_circle_fill_top regression: fail");
    end else if (fail_count == 0 && pending == 0) begin
      $display("mask_rect_circle_fill_top regression: pass");
    end else begin
      $display("mask_rect_circle_fill_top regression: fail");
    end
    $finish;
  end
endmodule
